### design/baro_pressure_temp_compensation_core_assert.svh
// Assertion macros for the barometric compensation core.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_CORE_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bpc_pkg.sv
// Types and constants shared by the barometric compensation core.
`default_nettype none
package bpc_pkg;

  localparam int TEMP_REF_CENTI  = 2000;
  localparam int TEMP_VLOW_CENTI = -1500;

  typedef enum logic [1:0] {
    LVL_NONE = 2'd0,
    LVL_LOW  = 2'd1,
    LVL_VLOW = 2'd2
  } bpc_level_t;

  typedef struct packed {
    logic [15:0] pressure_sensitivity;
    logic [15:0] pressure_offset;
    logic [15:0] sensitivity_temp_coeff;
    logic [15:0] offset_temp_coeff;
    logic [15:0] reference_temperature;
    logic [15:0] temperature_coeff;
  } bpc_cal_t;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } bpc_in_t;

  typedef struct packed {
    logic signed [19:0] temperature_centi;
    logic signed [31:0] pressure_pascal;
    logic        [1:0]  correction_level;
  } bpc_out_t;

  // First-order results
  typedef struct packed {
    logic        [23:0] d1;
    logic signed [18:0] temp1;
    logic signed [17:0] dlo;
    logic signed [18:0] dvl;
    logic        [17:0] t2;
    logic signed [39:0] off1;
    logic signed [39:0] sens1;
  } bpc_fo_t;

  // Fully corrected offset and sensitivity
  typedef struct packed {
    logic        [23:0] d1;
    logic signed [19:0] temp;
    logic signed [39:0] off;
    logic signed [39:0] sens;
    bpc_level_t         level;
  } bpc_so_t;

endpackage
`default_nettype wire

### design/baro_pressure_temp_compensation_core.sv
// Barometric pressure and temperature compensation core, top level.
// Takes one raw pressure/temperature pair per cycle while in_ready is high and returns
// the compensated temperature (0.01 degC) and pressure (Pa), with the second-order level
// applied. Throughput is one item per clock while the output is not stalled, set by the
// nine-stage pipeline; a stall on the output backs up through the stages and
// only drops in_ready once every stage holds an item. Calibration words must be written
// through cfg_we/cfg_addr/cfg_wdata only while the pipeline is empty; the block does not enforce this.
`default_nettype none
`include "baro_pressure_temp_compensation_core_assert.svh"
module baro_pressure_temp_compensation_core import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  bpc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output bpc_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam logic [2:0] REG_PRESSURE_SENSITIVITY   = 3'd0;
  localparam logic [2:0] REG_PRESSURE_OFFSET        = 3'd1;
  localparam logic [2:0] REG_SENSITIVITY_TEMP_COEFF = 3'd2;
  localparam logic [2:0] REG_OFFSET_TEMP_COEFF      = 3'd3;
  localparam logic [2:0] REG_REFERENCE_TEMPERATURE  = 3'd4;
  localparam logic [2:0] REG_TEMPERATURE_COEFF      = 3'd5;

  bpc_cal_t cal_r;

  logic    fo_valid, fo_ready;
  bpc_fo_t fo_data;
  logic    so_valid, so_ready;
  bpc_so_t so_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r.pressure_sensitivity   <= 16'd40127;
      cal_r.pressure_offset        <= 16'd36924;
      cal_r.sensitivity_temp_coeff <= 16'd23317;
      cal_r.offset_temp_coeff      <= 16'd23282;
      cal_r.reference_temperature  <= 16'd33464;
      cal_r.temperature_coeff      <= 16'd28312;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PRESSURE_SENSITIVITY:   cal_r.pressure_sensitivity   <= cfg_wdata;
        REG_PRESSURE_OFFSET:        cal_r.pressure_offset        <= cfg_wdata;
        REG_SENSITIVITY_TEMP_COEFF: cal_r.sensitivity_temp_coeff <= cfg_wdata;
        REG_OFFSET_TEMP_COEFF:      cal_r.offset_temp_coeff      <= cfg_wdata;
        REG_REFERENCE_TEMPERATURE:  cal_r.reference_temperature  <= cfg_wdata;
        REG_TEMPERATURE_COEFF:      cal_r.temperature_coeff      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bpc_first_order u_first_order (
    .clk       (clk),
    .rst_n     (rst_n),
    .cal       (cal_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (fo_valid),
    .out_ready (fo_ready),
    .out_data  (fo_data)
  );

  bpc_second_order u_second_order (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fo_valid),
    .in_ready  (fo_ready),
    .in_data   (fo_data),
    .out_valid (so_valid),
    .out_ready (so_ready),
    .out_data  (so_data)
  );

  bpc_pressure u_pressure (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (so_valid),
    .in_ready  (so_ready),
    .in_data   (so_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Backpressure only when every stage is full
  `BPC_ASSERT_IMPL(a_empty_out_ready, clk, rst_n, !out_valid, in_ready, "in_ready low with empty output stage")
  `BPC_ASSERT_NEXT(a_full_holds, clk, rst_n, !in_ready, out_valid, "full pipeline lost its output item")
  // Level agrees with the result temperature
  `BPC_ASSERT_IMPL(a_level_none, clk, rst_n, out_valid, ((out_data.correction_level == LVL_NONE) == ($signed(out_data.temperature_centi) >= 20'sd2000)), "correction level disagrees with temperature")
  `BPC_ASSERT_IMPL(a_level_vlow, clk, rst_n, out_valid && (out_data.correction_level == LVL_VLOW), ($signed(out_data.temperature_centi) < -20'sd1500), "very-low level above threshold")

endmodule
`default_nettype wire

### design/bpc_first_order.sv
// First-order compensation: dT, coefficient products, base offset and sensitivity.
`default_nettype none
module bpc_first_order import bpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  bpc_cal_t cal,
  input  logic     in_valid,
  output logic     in_ready,
  input  bpc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bpc_fo_t  out_data
);

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  logic        [23:0] d1_s1_r, d1_s2_r;
  logic signed [24:0] dt_r;
  logic signed [41:0] m_t_r, m_off_r, m_sens_r;
  logic signed [49:0] m_sq_r;
  bpc_fo_t            fo_r;

  logic signed [24:0] dt_nxt;
  logic signed [17:0] dlo;
  bpc_fo_t            fo_nxt;

  assign adv3     = !v3_r || out_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  assign dt_nxt = $signed({1'b0, in_data.raw_temperature})
                - $signed({1'b0, cal.reference_temperature, 8'h00});

  assign dlo = m_t_r[40:23];

  always_comb begin
    fo_nxt       = '0;
    fo_nxt.d1    = d1_s2_r;
    fo_nxt.dlo   = dlo;
    fo_nxt.temp1 = 19'(dlo) + 19'(TEMP_REF_CENTI);
    fo_nxt.dvl   = 19'(dlo) + 19'(TEMP_REF_CENTI - TEMP_VLOW_CENTI);
    fo_nxt.t2    = m_sq_r[48:31];
    fo_nxt.off1  = $signed({8'h00, cal.pressure_offset, 16'h0000})
                 + 40'($signed(m_off_r[41:7]));
    fo_nxt.sens1 = $signed({9'h000, cal.pressure_sensitivity, 15'h0000})
                 + 40'($signed(m_sens_r[41:8]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      d1_s1_r <= in_data.raw_pressure;
      dt_r    <= dt_nxt;
    end
    if (adv2) begin
      d1_s2_r  <= d1_s1_r;
      m_t_r    <= dt_r * $signed({1'b0, cal.temperature_coeff});
      m_off_r  <= dt_r * $signed({1'b0, cal.offset_temp_coeff});
      m_sens_r <= dt_r * $signed({1'b0, cal.sensitivity_temp_coeff});
      m_sq_r   <= dt_r * dt_r;
    end
    if (adv3) begin
      fo_r <= fo_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = fo_r;

endmodule
`default_nettype wire

### design/bpc_second_order.sv
// Low-temperature corrections to temperature, offset and sensitivity.
`default_nettype none
module bpc_second_order import bpc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  bpc_fo_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output bpc_so_t out_data
);

  logic v4_r, v5_r, v6_r;
  logic adv4, adv5, adv6;

  // stage 4
  logic        [23:0] d1_s4_r;
  logic signed [18:0] temp1_r;
  logic        [17:0] t2_r;
  logic signed [39:0] off1_s4_r, sens1_s4_r;
  logic        [33:0] sq_lo_r;
  logic        [34:0] sq_vl_r;
  logic               low_r, vlow_r;

  // stage 5
  logic        [23:0] d1_s5_r;
  logic signed [19:0] temp_s5_r;
  logic signed [39:0] off1_s5_r, sens1_s5_r;
  logic        [38:0] off2_r, sens2_r;
  bpc_level_t         level_s5_r;

  bpc_so_t so_r;

  logic signed [35:0] sq_lo_full;
  logic signed [37:0] sq_vl_full;
  logic        [36:0] lo5;
  logic        [38:0] vl7, vl11;
  logic        [38:0] off2_nxt, sens2_nxt;
  logic signed [19:0] temp_nxt;
  bpc_level_t         level_nxt;

  assign adv6     = !v6_r || out_ready;
  assign adv5     = !v5_r || adv6;
  assign adv4     = !v4_r || adv5;
  assign in_ready = adv4;

  assign sq_lo_full = in_data.dlo * in_data.dlo;
  assign sq_vl_full = in_data.dvl * in_data.dvl;

  assign lo5  = 37'(sq_lo_r) * 37'd5;
  assign vl7  = 39'(sq_vl_r) * 39'd7;
  assign vl11 = 39'(sq_vl_r) * 39'd11;

  always_comb begin
    off2_nxt  = '0;
    sens2_nxt = '0;
    temp_nxt  = 20'(temp1_r);
    level_nxt = LVL_NONE;
    if (low_r) begin
      off2_nxt  = 39'(lo5[36:1]);
      sens2_nxt = 39'(lo5[36:2]);
      temp_nxt  = 20'(temp1_r) - $signed({2'b00, t2_r});
      level_nxt = LVL_LOW;
      if (vlow_r) begin
        off2_nxt  = 39'(lo5[36:1]) + vl7;
        sens2_nxt = 39'(lo5[36:2]) + 39'(vl11[38:1]);
        level_nxt = LVL_VLOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (adv4) v4_r <= in_valid;
      if (adv5) v5_r <= v4_r;
      if (adv6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      d1_s4_r    <= in_data.d1;
      temp1_r    <= in_data.temp1;
      t2_r       <= in_data.t2;
      off1_s4_r  <= in_data.off1;
      sens1_s4_r <= in_data.sens1;
      sq_lo_r    <= sq_lo_full[33:0];
      sq_vl_r    <= sq_vl_full[34:0];
      low_r      <= in_data.dlo[17];
      vlow_r     <= in_data.dvl[18];
    end
    if (adv5) begin
      d1_s5_r    <= d1_s4_r;
      temp_s5_r  <= temp_nxt;
      off1_s5_r  <= off1_s4_r;
      sens1_s5_r <= sens1_s4_r;
      off2_r     <= off2_nxt;
      sens2_r    <= sens2_nxt;
      level_s5_r <= level_nxt;
    end
    if (adv6) begin
      so_r.d1    <= d1_s5_r;
      so_r.temp  <= temp_s5_r;
      so_r.off   <= off1_s5_r - $signed({1'b0, off2_r});
      so_r.sens  <= sens1_s5_r - $signed({1'b0, sens2_r});
      so_r.level <= level_s5_r;
    end
  end

  assign out_valid = v6_r;
  assign out_data  = so_r;

endmodule
`default_nettype wire

### design/bpc_pressure.sv
// Pressure from raw reading, sensitivity and offset, via split partial products.
`default_nettype none
module bpc_pressure import bpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bpc_so_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bpc_out_t out_data
);

  logic v7_r, v8_r, v9_r;
  logic adv7, adv8, adv9;

  logic        [43:0] pp_lo_r;
  logic signed [43:0] pp_hi_r;
  logic signed [63:0] prod_r;
  logic signed [39:0] off_s7_r, off_s8_r;
  logic signed [19:0] temp_s7_r, temp_s8_r;
  bpc_level_t         level_s7_r, level_s8_r;
  bpc_out_t           out_r;

  logic signed [44:0] pp_hi_full;
  logic signed [63:0] prod_nxt;
  logic signed [43:0] diff;

  assign adv9     = !v9_r || out_ready;
  assign adv8     = !v8_r || adv9;
  assign adv7     = !v7_r || adv8;
  assign in_ready = adv7;

  assign pp_hi_full = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[39:20]);
  assign prod_nxt   = $signed({pp_hi_r, 20'h00000}) + $signed({20'h00000, pp_lo_r});
  assign diff       = 44'($signed(prod_r[63:21])) - 44'(off_s8_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else begin
      if (adv7) v7_r <= in_valid;
      if (adv8) v8_r <= v7_r;
      if (adv9) v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv7) begin
      pp_lo_r    <= in_data.d1 * in_data.sens[19:0];
      pp_hi_r    <= pp_hi_full[43:0];
      off_s7_r   <= in_data.off;
      temp_s7_r  <= in_data.temp;
      level_s7_r <= in_data.level;
    end
    if (adv8) begin
      prod_r     <= prod_nxt;
      off_s8_r   <= off_s7_r;
      temp_s8_r  <= temp_s7_r;
      level_s8_r <= level_s7_r;
    end
    if (adv9) begin
      out_r.temperature_centi <= temp_s8_r;
      out_r.pressure_pascal   <= 32'($signed(diff[43:15]));
      out_r.correction_level  <= level_s8_r;
    end
  end

  assign out_valid = v9_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### tb/sv/baro_pressure_temp_compensation_core_test.sv
`timescale 1ns / 100ps
// Testbench for the barometric pressure and temperature compensation core.
module baro_pressure_temp_compensation_core_test;
  import bpc_pkg::*;

  typedef enum logic [2:0] {
    CAL_PRESS_SENS = 3'd0,
    CAL_PRESS_OFF  = 3'd1,
    CAL_SENS_TCO   = 3'd2,
    CAL_OFF_TCO    = 3'd3,
    CAL_REF_TEMP   = 3'd4,
    CAL_TEMP_COEFF = 3'd5,
    CAL_SPARE_LO   = 3'd6,
    CAL_SPARE_HI   = 3'd7
  } cal_index_t;

  localparam int          NUM_CAL      = 6;
  localparam logic [23:0] RAW_MAX      = 24'hFFFFFF;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          CYCLE_LIMIT  = 200000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  bpc_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  bpc_out_t    out_data;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_addr  = 3'd0;
  logic [15:0] cfg_wdata = 16'd0;

  logic [15:0] cal_words [NUM_CAL] = '{16'd40127, 16'd36924, 16'd23317,
                                       16'd23282, 16'd33464, 16'd28312};
  bpc_out_t    expected_readings [$];
  int          send_idle_pct  = 22;
  int          recv_idle_pct  = 59;
  int          mismatch_count = 0;
  int          cycle_count    = 0;

  baro_pressure_temp_compensation_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint first_order_temp(longint raw_t);
    longint dt;
    dt = raw_t - longint'(cal_words[CAL_REF_TEMP]) * 256;
    return TEMP_REF_CENTI + ((dt * longint'(cal_words[CAL_TEMP_COEFF])) >>> 23);
  endfunction

  function automatic bpc_out_t compensate(bpc_in_t item);
    longint     raw_p, dt, temp, off, sens, t2, dlo, dvl, off2, sens2, p;
    bpc_level_t level;
    bpc_out_t   res;
    raw_p = longint'(item.raw_pressure);
    dt    = longint'(item.raw_temperature) - longint'(cal_words[CAL_REF_TEMP]) * 256;
    temp  = first_order_temp(longint'(item.raw_temperature));
    off   = longint'(cal_words[CAL_PRESS_OFF]) * 65536
            + ((longint'(cal_words[CAL_OFF_TCO]) * dt) >>> 7);
    sens  = longint'(cal_words[CAL_PRESS_SENS]) * 32768
            + ((longint'(cal_words[CAL_SENS_TCO]) * dt) >>> 8);
    level = LVL_NONE;
    if (temp < TEMP_REF_CENTI) begin
      t2    = (dt * dt) >>> 31;
      dlo   = temp - TEMP_REF_CENTI;
      off2  = (5 * dlo * dlo) >>> 1;
      sens2 = (5 * dlo * dlo) >>> 2;
      level = LVL_LOW;
      if (temp < TEMP_VLOW_CENTI) begin
        dvl   = temp - TEMP_VLOW_CENTI;
        off2  = off2 + 7 * dvl * dvl;
        sens2 = sens2 + ((11 * dvl * dvl) >>> 1);
        level = LVL_VLOW;
      end
      temp = temp - t2;
      off  = off - off2;
      sens = sens - sens2;
    end
    p = (((raw_p * sens) >>> 21) - off) >>> 15;
    res.temperature_centi = temp[19:0];
    res.pressure_pascal   = p[31:0];
    res.correction_level  = level;
    return res;
  endfunction

  // smallest raw temperature whose first-order temperature reaches target, or RAW_MAX if none does
  function automatic logic [23:0] raw_temp_at(longint target);
    longint lo, hi, mid;
    lo = 0;
    hi = longint'(RAW_MAX);
    if (first_order_temp(hi) < target) return RAW_MAX;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (first_order_temp(mid) >= target) hi = mid;
      else lo = mid + 1;
    end
    return lo[23:0];
  endfunction

  function automatic logic [15:0] random_cal_word();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] random_raw();
    case ($urandom_range(7))
      0: return 24'h000000;
      1: return RAW_MAX;
      default: return 24'($urandom);
    endcase
  endfunction

  // mostly near the reference point, where the correction bands lie
  function automatic logic [23:0] random_raw_temp();
    longint center;
    if ($urandom_range(2) == 0) return random_raw();
    center = longint'(cal_words[CAL_REF_TEMP]) * 256
             + longint'($urandom_range(1 << 22)) - (1 << 21);
    if (center < 0) center = 0;
    if (center > longint'(RAW_MAX)) center = longint'(RAW_MAX);
    return center[23:0];
  endfunction

  task automatic send_reading(input logic [23:0] raw_p, input logic [23:0] raw_t);
    bpc_in_t item;
    item.raw_pressure    = raw_p;
    item.raw_temperature = raw_t;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_readings.push_back(compensate(item));
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cal(input cal_index_t index, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (index < NUM_CAL) cal_words[index] = value;
  endtask

  task automatic test_reset_calibration();
    send_reading(24'h000000, 24'h000000);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading(RAW_MAX, 24'h000000);
    send_reading(24'h000000, RAW_MAX);
    send_reading(24'hAAAAAA, 24'h555555);
    send_reading(24'h555555, 24'hAAAAAA);
  endtask

  task automatic test_correction_thresholds();
    logic [23:0] at_ref, at_vlow;
    at_ref  = raw_temp_at(TEMP_REF_CENTI);
    at_vlow = raw_temp_at(TEMP_VLOW_CENTI);
    send_reading(random_raw(), at_ref - 24'd1);
    send_reading(random_raw(), at_ref);
    send_reading(random_raw(), at_vlow - 24'd1);
    send_reading(random_raw(), at_vlow);
    send_reading(random_raw(), {cal_words[CAL_REF_TEMP], 8'h00});
  endtask

  task automatic test_calibration_extremes();
    drain_pipeline();
    for (int r = 0; r < NUM_CAL; r++) write_cal(cal_index_t'(r), 16'h0000);
    send_reading(24'h000000, 24'h000000);
    send_reading(RAW_MAX, RAW_MAX);
    drain_pipeline();
    for (int r = 0; r < NUM_CAL; r++) write_cal(cal_index_t'(r), 16'hFFFF);
    send_reading(24'h000000, 24'h000000);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading(RAW_MAX, 24'h000000);
    send_reading(24'h000000, RAW_MAX);
  endtask

  // writes past the last register must leave the calibration alone
  task automatic test_spare_index();
    drain_pipeline();
    write_cal(CAL_PRESS_SENS, 16'd40127);
    write_cal(CAL_PRESS_OFF, 16'd36924);
    write_cal(CAL_SENS_TCO, 16'd23317);
    write_cal(CAL_OFF_TCO, 16'd23282);
    write_cal(CAL_REF_TEMP, 16'd33464);
    write_cal(CAL_TEMP_COEFF, 16'd28312);
    write_cal(CAL_SPARE_LO, 16'hFFFF);
    write_cal(CAL_SPARE_HI, 16'h0000);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading(24'h000000, 24'h000000);
  endtask

  task automatic test_random_readings(input int send_pct, input int recv_pct, input int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int set = 0; set < 4; set++) begin
      drain_pipeline();
      for (int r = 0; r < NUM_CAL; r++) write_cal(cal_index_t'(r), random_cal_word());
      for (int n = 0; n < count / 4; n++) send_reading(random_raw(), random_raw_temp());
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_reading
    bpc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected item, expected none, got %h", $time, out_data);
        mismatch_count++;
      end else begin
        want = expected_readings.pop_front();
        if (out_data.temperature_centi !== want.temperature_centi) begin
          $display("%0t: temperature_centi expected %0d got %0d", $time,
                   want.temperature_centi, out_data.temperature_centi);
          mismatch_count++;
        end
        if (out_data.pressure_pascal !== want.pressure_pascal) begin
          $display("%0t: pressure_pascal expected %0d got %0d", $time,
                   want.pressure_pascal, out_data.pressure_pascal);
          mismatch_count++;
        end
        if (out_data.correction_level !== want.correction_level) begin
          $display("%0t: correction_level expected %0d got %0d", $time,
                   want.correction_level, out_data.correction_level);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("baro_pressure_temp_compensation_core_test failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_calibration();
    test_correction_thresholds();
    test_calibration_extremes();
    test_spare_index();
    test_random_readings(22, 59, 216);
    test_random_readings(59, 22, 216);
    test_random_readings(0, 0, 216);
    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("baro_pressure_temp_compensation_core_test passed");
    end else begin
      $display("baro_pressure_temp_compensation_core_test failed");
    end
    $finish;
  end

endmodule
